// ----- design/bps_pkg.sv -----
`timescale 1ns / 1ps
// Package for the brew phase sequencer: field widths, operation and phase codes,
// relay bit positions, configuration register indexes and the shared structs.
// No dependencies.
package bps_pkg;

	localparam int TempW   = 12;
	localparam int DurW    = 24;
	localparam int TimeW   = 32;
	localparam int RelayW  = 7;
	localparam int BeepW   = 4;
	localparam int CfgIdxW = 3;

	// Fixed transfer time from pot 2 into pot 3.
	localparam logic [DurW-1:0] TransferBoilMs = 24'd30000;

	localparam logic [BeepW-1:0] BeepNone  = 4'd0;
	localparam logic [BeepW-1:0] BeepPhase = 4'd1;
	localparam logic [BeepW-1:0] BeepDone  = 4'd10;

	typedef enum logic [1:0] {
		OP_PASS  = 2'd0,
		OP_START = 2'd1,
		OP_STOP  = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		PH_IDLE     = 3'd0,
		PH_HEAT1    = 3'd1,
		PH_DRAIN1   = 3'd2,
		PH_MASH     = 3'd3,
		PH_DRAIN2   = 3'd4,
		PH_SPARGE   = 3'd5,
		PH_TRANSFER = 3'd6,
		PH_BOIL     = 3'd7
	} phase_t;

	// Relay bit positions inside the relay word.
	localparam int R_HEAT1  = 0;
	localparam int R_HEAT2  = 1;
	localparam int R_HEAT3  = 2;
	localparam int R_VALVE1 = 3;
	localparam int R_VALVE2 = 4;
	localparam int R_VALVE3 = 5;
	localparam int R_PUMP   = 6;

	// Configuration register indexes.
	localparam logic [CfgIdxW-1:0] CFG_SETPOINT_POT1 = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_SETPOINT_POT2 = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_SETPOINT_POT3 = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_DRAIN_ONE_MS  = 3'd3;
	localparam logic [CfgIdxW-1:0] CFG_MASH_MS       = 3'd4;
	localparam logic [CfgIdxW-1:0] CFG_DRAIN_TWO_MS  = 3'd5;
	localparam logic [CfgIdxW-1:0] CFG_SPARGE_MS     = 3'd6;
	localparam logic [CfgIdxW-1:0] CFG_BOIL_MS       = 3'd7;

	typedef struct packed {
		logic signed [TempW-1:0] setpoint_pot1;
		logic signed [TempW-1:0] setpoint_pot2;
		logic signed [TempW-1:0] setpoint_pot3;
		logic [DurW-1:0]         drain_one_ms;
		logic [DurW-1:0]         mash_ms;
		logic [DurW-1:0]         drain_two_ms;
		logic [DurW-1:0]         sparge_ms;
		logic [DurW-1:0]         boil_ms;
	} cfg_t;

	typedef struct packed {
		phase_t              phase;
		logic                active;
		logic [RelayW-1:0]   relays;
		logic [TimeW-1:0]    deadline;
		logic [TimeW-1:0]    half_deadline;
		logic                mash_started;
	} seq_state_t;

endpackage

// ----- design/bps_cfg_regs.sv -----
`timescale 1ns / 1ps
// Configuration register file of the brew phase sequencer.
// Depends on bps_pkg.
module bps_cfg_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [bps_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [bps_pkg::DurW-1:0]     cfg_data,
	output bps_pkg::cfg_t                cfg
);
	import bps_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.setpoint_pot1 <= 12'sd1040;
			cfg_q.setpoint_pot2 <= 12'sd480;
			cfg_q.setpoint_pot3 <= 12'sd1600;
			cfg_q.drain_one_ms  <= 24'd30000;
			cfg_q.mash_ms       <= 24'd90000;
			cfg_q.drain_two_ms  <= 24'd30000;
			cfg_q.sparge_ms     <= 24'd30000;
			cfg_q.boil_ms       <= 24'd90000;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SETPOINT_POT1: cfg_q.setpoint_pot1 <= signed'(cfg_data[TempW-1:0]);
				CFG_SETPOINT_POT2: cfg_q.setpoint_pot2 <= signed'(cfg_data[TempW-1:0]);
				CFG_SETPOINT_POT3: cfg_q.setpoint_pot3 <= signed'(cfg_data[TempW-1:0]);
				CFG_DRAIN_ONE_MS:  cfg_q.drain_one_ms  <= cfg_data;
				CFG_MASH_MS:       cfg_q.mash_ms       <= cfg_data;
				CFG_DRAIN_TWO_MS:  cfg_q.drain_two_ms  <= cfg_data;
				CFG_SPARGE_MS:     cfg_q.sparge_ms     <= cfg_data;
				CFG_BOIL_MS:       cfg_q.boil_ms       <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- design/bps_step.sv -----
`timescale 1ns / 1ps
// Next-state logic of the brew phase sequencer for one item, phases falling through.
// Depends on bps_pkg.
module bps_step (
	input  logic [1:0]                      operation,
	input  logic [bps_pkg::TimeW-1:0]       now_ms,
	input  logic signed [bps_pkg::TempW-1:0] temp_pot1,
	input  logic signed [bps_pkg::TempW-1:0] temp_pot2,
	input  logic signed [bps_pkg::TempW-1:0] temp_pot3,
	input  bps_pkg::cfg_t                   cfg,
	input  bps_pkg::seq_state_t             cur,
	output bps_pkg::seq_state_t             nxt,
	output logic [bps_pkg::BeepW-1:0]       beep_count
);
	import bps_pkg::*;

	// All deadline candidates are summed in parallel. The carry out of each sum
	// settles both compares against now, since now >= now + d holds exactly when
	// d is zero or the sum wrapped.
	logic [TimeW:0] sum_d1, sum_mash, sum_half, sum_d2, sum_sp, sum_tb, sum_boil;
	logic           ge_d1, ge_d2, ge_sp, ge_tb;
	logic           ge_half, le_mash;
	logic           ge_stored, le_stored, ge_stored_half;
	logic           th1, th2, th3;

	phase_t            ph;
	logic              act, ms, beep_one, beep_end;
	logic [RelayW-1:0] rel;
	logic [TimeW-1:0]  dl, hdl;
	logic              dl_ge, dl_le, hdl_ge;

	assign sum_d1   = {1'b0, now_ms} + (TimeW+1)'(cfg.drain_one_ms);
	assign sum_mash = {1'b0, now_ms} + (TimeW+1)'(cfg.mash_ms);
	assign sum_half = {1'b0, now_ms} + (TimeW+1)'(cfg.mash_ms[DurW-1:1]);
	assign sum_d2   = {1'b0, now_ms} + (TimeW+1)'(cfg.drain_two_ms);
	assign sum_sp   = {1'b0, now_ms} + (TimeW+1)'(cfg.sparge_ms);
	assign sum_tb   = {1'b0, now_ms} + (TimeW+1)'(TransferBoilMs);
	assign sum_boil = {1'b0, now_ms} + (TimeW+1)'(cfg.boil_ms);

	assign ge_d1   = sum_d1[TimeW] || (cfg.drain_one_ms == '0);
	assign ge_d2   = sum_d2[TimeW] || (cfg.drain_two_ms == '0);
	assign ge_sp   = sum_sp[TimeW] || (cfg.sparge_ms == '0);
	assign ge_tb   = sum_tb[TimeW] || (TransferBoilMs == '0);
	assign ge_half = sum_half[TimeW] || (cfg.mash_ms[DurW-1:1] == '0);
	assign le_mash = !sum_mash[TimeW];

	assign ge_stored      = now_ms >= cur.deadline;
	assign le_stored      = cur.deadline >= now_ms;
	assign ge_stored_half = now_ms >= cur.half_deadline;

	assign th1 = cfg.setpoint_pot1 >= temp_pot1;
	assign th2 = cfg.setpoint_pot2 >= temp_pot2;
	assign th3 = cfg.setpoint_pot3 >= temp_pot3;

	// The deadline is carried with its two compare results against now so that
	// a phase entered earlier in the same pass needs no second adder or compare.
	always_comb begin
		ph       = cur.phase;
		act      = cur.active;
		rel      = cur.relays;
		dl       = cur.deadline;
		dl_ge    = ge_stored;
		dl_le    = le_stored;
		hdl      = cur.half_deadline;
		hdl_ge   = ge_stored_half;
		ms       = cur.mash_started;
		beep_one = 1'b0;
		beep_end = 1'b0;

		case (op_t'(operation))
			OP_START: begin
				ph  = PH_HEAT1;
				act = 1'b1;
				ms  = 1'b0;
			end
			OP_STOP: begin
				ph       = PH_IDLE;
				act      = 1'b0;
				rel      = '0;
				beep_one = 1'b1;
			end
			OP_PASS: begin
				if (act) begin
					if (ph == PH_HEAT1) begin
						if (th1) begin
							rel[R_HEAT1] = 1'b1;
						end else begin
							rel[R_HEAT1]  = 1'b0;
							rel[R_VALVE1] = 1'b1;
							ph       = PH_DRAIN1;
							dl       = sum_d1[TimeW-1:0];
							dl_ge    = ge_d1;
							dl_le    = !sum_d1[TimeW];
							beep_one = 1'b1;
						end
					end
					if (ph == PH_DRAIN1 && dl_ge) begin
						rel[R_VALVE1] = 1'b0;
						if (th2) begin
							rel[R_HEAT2] = 1'b1;
						end else begin
							ph       = PH_MASH;
							beep_one = 1'b1;
						end
					end
					if (ph == PH_MASH) begin
						rel[R_VALVE2] = 1'b1;
						rel[R_PUMP]   = 1'b1;
						rel[R_HEAT2]  = th2;
						if (!ms) begin
							dl     = sum_mash[TimeW-1:0];
							dl_ge  = sum_mash[TimeW] || (cfg.mash_ms == '0);
							dl_le  = le_mash;
							hdl    = sum_half[TimeW-1:0];
							hdl_ge = ge_half;
						end
						if (hdl_ge) begin
							rel[R_HEAT1] = th1;
						end
						if (dl_le) begin
							ms = 1'b1;
						end else begin
							rel[R_PUMP]   = 1'b0;
							rel[R_HEAT1]  = 1'b0;
							rel[R_VALVE2] = 1'b0;
							rel[R_HEAT2]  = 1'b0;
							rel[R_VALVE3] = 1'b1;
							ph       = PH_DRAIN2;
							dl       = sum_d2[TimeW-1:0];
							dl_ge    = ge_d2;
							dl_le    = !sum_d2[TimeW];
							beep_one = 1'b1;
						end
					end
					if (ph == PH_DRAIN2 && dl_ge) begin
						rel[R_VALVE1] = 1'b1;
						ph       = PH_SPARGE;
						dl       = sum_sp[TimeW-1:0];
						dl_ge    = ge_sp;
						dl_le    = !sum_sp[TimeW];
						beep_one = 1'b1;
					end
					if (ph == PH_SPARGE && dl_ge) begin
						rel[R_VALVE1] = 1'b0;
						ph       = PH_TRANSFER;
						dl       = sum_tb[TimeW-1:0];
						dl_ge    = ge_tb;
						dl_le    = !sum_tb[TimeW];
						beep_one = 1'b1;
					end
					if (ph == PH_TRANSFER && dl_ge) begin
						rel[R_VALVE3] = 1'b0;
						if (th3) begin
							rel[R_HEAT3] = 1'b1;
						end else begin
							ph       = PH_BOIL;
							dl       = sum_boil[TimeW-1:0];
							dl_ge    = sum_boil[TimeW] || (cfg.boil_ms == '0);
							dl_le    = !sum_boil[TimeW];
							beep_one = 1'b1;
						end
					end
					if (ph == PH_BOIL) begin
						rel[R_HEAT3] = th3;
						if (!dl_le) begin
							rel[R_HEAT3] = 1'b0;
							act      = 1'b0;
							ph       = PH_IDLE;
							beep_end = 1'b1;
						end
					end
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		nxt.phase         = ph;
		nxt.active        = act;
		nxt.relays        = rel;
		nxt.deadline      = dl;
		nxt.half_deadline = hdl;
		nxt.mash_started  = ms;
		if (beep_end) begin
			beep_count = BeepDone;
		end else if (beep_one) begin
			beep_count = BeepPhase;
		end else begin
			beep_count = BeepNone;
		end
	end

endmodule

// ----- design/brew_phase_sequencer.sv -----
`timescale 1ns / 1ps
// Top level of the brew phase sequencer: input register, sequence state, result register.
// Depends on bps_pkg, bps_cfg_regs and bps_step.
//
//  Channel   Handshake            Payload
//  s_        s_tvalid / s_tready  s_tuser operation, s_tdata now_ms and temperatures
//  m_        m_tvalid / m_tready  m_tdata relays, running, phase, beep_count
//  cfg_      cfg_we               cfg_index, cfg_data
//
// One item per clock cycle sustained while the result side is ready; a result is
// offered from the result register once its item moves on from the input register.
// The sequence state is updated as an item leaves the input register for the result
// register, so the next item always sees it. A stalled result holds the input
// register, and the input side stalls only when both registers are full.
// Reset restores the configuration defaults and returns the sequence to idle.
module brew_phase_sequencer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [71:0]                 s_tdata,  // now_ms, temp_pot1, temp_pot2, temp_pot3, zero fill
	input  logic [1:0]                  s_tuser,  // operation
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [15:0]                 m_tdata,  // heater_one, heater_two, heater_three,
	                                              // valve_one, valve_two, valve_three, pump_on,
	                                              // running, phase, beep_count, zero fill
	input  logic                        cfg_we,
	input  logic [bps_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [bps_pkg::DurW-1:0]    cfg_data
);
	import bps_pkg::*;

	cfg_t       cfg;
	seq_state_t state_q, state_nxt;

	logic                     valid_s1;
	logic [1:0]               op_s1;
	logic [TimeW-1:0]         now_s1;
	logic signed [TempW-1:0]  temp1_s1, temp2_s1, temp3_s1;

	logic                     valid_s2;
	logic [15:0]              data_s2;

	logic [BeepW-1:0]         beep;
	logic [15:0]              result;
	logic                     advance;

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	bps_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bps_step u_step (
		.operation  (op_s1),
		.now_ms     (now_s1),
		.temp_pot1  (temp1_s1),
		.temp_pot2  (temp2_s1),
		.temp_pot3  (temp3_s1),
		.cfg        (cfg),
		.cur        (state_q),
		.nxt        (state_nxt),
		.beep_count (beep)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1    <= s_tuser;
			now_s1   <= s_tdata[31:0];
			temp1_s1 <= signed'(s_tdata[43:32]);
			temp2_s1 <= signed'(s_tdata[55:44]);
			temp3_s1 <= signed'(s_tdata[67:56]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase         <= PH_IDLE;
			state_q.active        <= 1'b0;
			state_q.relays        <= '0;
			state_q.deadline      <= '0;
			state_q.half_deadline <= '0;
			state_q.mash_started  <= 1'b0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Result word packing, lowest field first.
	always_comb begin
		result        = '0;
		result[6:0]   = state_nxt.relays;
		result[7]     = state_nxt.active;
		result[10:8]  = state_nxt.phase;
		result[14:11] = beep;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			data_s2 <= result;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = data_s2;

endmodule
